>>> rtl/sowc_pkg.sv
package sowc_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned RotWidth  = 5;

    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } shift_kind_t;

    localparam logic [DataWidth-1:0] ALL_ONES = {DataWidth{1'b1}};
    localparam logic [DataWidth-1:0] RRX_MASK = {1'b0, {(DataWidth-1){1'b1}}};

    typedef struct packed {
        logic [DataWidth-1:0] value;
        logic [RotWidth-1:0]  rot;
        logic [DataWidth-1:0] mask;
        logic                 fill;
        logic                 carry;
    } stage_t;

endpackage

>>> rtl/shifter_operand_with_carry_unit.sv
// operand-2 barrel shifter with carry out, four register stages
// an item is taken at any rising edge with start high and busy low;
// busy is always low, so one item can be taken every cycle
// shift_encoding bit 0 selects the amount source (immediate or register
// byte), bits 2:1 the kind (lsl, lsr, asr, ror), bits 7:3 the immediate
// the result of an item passes through s1_reg, s2_reg, s3_reg and the
// output registers, then is on shifted_value and shift_carry, with done
// high, for exactly one cycle; throughput one item per cycle
// stage 1 decodes the amount into a rotate count, a keep mask, a fill bit
// and the carry; stage 2 rotates by multiples of eight, stage 3 by the
// remaining zero to seven bits, stage 4 applies the mask and fill into
// the output registers
// the latency is set by these four register stages
// reset clears every valid bit, so no result appears from items in flight;
// the receiver cannot stall, so the pipeline never holds
module shifter_operand_with_carry_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  shift_encoding,
    input  logic [31:0] operand_value,
    input  logic [7:0]  amount_reg_byte,
    input  logic        carry_in,
    output logic        done,
    output logic [31:0] shifted_value,
    output logic        shift_carry
);

    sowc_pkg::stage_t s1_next;
    sowc_pkg::stage_t s1_reg;
    sowc_pkg::stage_t s2_next;
    sowc_pkg::stage_t s2_reg;
    sowc_pkg::stage_t s3_next;
    sowc_pkg::stage_t s3_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic             v4_reg;
    logic [31:0]      value_next;
    logic [31:0]      value_reg;
    logic             carry_reg;

    logic                  from_reg;
    sowc_pkg::shift_kind_t kind;
    logic [7:0]            amt;
    logic [4:0]            amt_lo;
    logic                  amt_big;
    logic [4:0]            lsl_idx;
    logic [4:0]            amt_m1;

    assign busy     = 1'b0;
    assign from_reg = shift_encoding[0];
    assign kind     = sowc_pkg::shift_kind_t'(shift_encoding[2:1]);
    assign amt      = from_reg ? amount_reg_byte : {3'b000, shift_encoding[7:3]};
    assign amt_lo   = amt[4:0];
    assign amt_big  = amt[7:5] != 3'b000;
    assign lsl_idx  = 5'd0 - amt_lo;
    assign amt_m1   = amt_lo - 5'd1;

    // stage 1: decode
    always_comb
    begin
        s1_next.value = operand_value;
        s1_next.rot   = 5'd0;
        s1_next.mask  = sowc_pkg::ALL_ONES;
        s1_next.fill  = 1'b0;
        s1_next.carry = carry_in;
        if (!(from_reg && amount_reg_byte == 8'd0))
        begin
            unique case (kind)
                sowc_pkg::SHIFT_LSL:
                begin
                    if (amt == 8'd0)
                    begin
                        s1_next.carry = carry_in;
                    end
                    else if (!amt_big)
                    begin
                        s1_next.rot   = lsl_idx;
                        s1_next.mask  = sowc_pkg::ALL_ONES << amt_lo;
                        s1_next.carry = operand_value[lsl_idx];
                    end
                    else
                    begin
                        s1_next.mask  = '0;
                        s1_next.carry = (amt == 8'd32) ? operand_value[0] : 1'b0;
                    end
                end
                sowc_pkg::SHIFT_LSR:
                begin
                    if (amt != 8'd0 && !amt_big)
                    begin
                        s1_next.rot   = amt_lo;
                        s1_next.mask  = sowc_pkg::ALL_ONES >> amt_lo;
                        s1_next.carry = operand_value[amt_m1];
                    end
                    else
                    begin
                        s1_next.mask  = '0;
                        s1_next.carry = (amt == 8'd0 || amt == 8'd32) ?
                                        operand_value[31] : 1'b0;
                    end
                end
                sowc_pkg::SHIFT_ASR:
                begin
                    s1_next.fill = operand_value[31];
                    if (amt != 8'd0 && !amt_big)
                    begin
                        s1_next.rot   = amt_lo;
                        s1_next.mask  = sowc_pkg::ALL_ONES >> amt_lo;
                        s1_next.carry = operand_value[amt_m1];
                    end
                    else
                    begin
                        s1_next.mask  = '0;
                        s1_next.carry = operand_value[31];
                    end
                end
                sowc_pkg::SHIFT_ROR:
                begin
                    if (!from_reg && amt_lo == 5'd0)
                    begin
                        // rrx: rotate by one, top bit replaced by carry in
                        s1_next.rot   = 5'd1;
                        s1_next.mask  = sowc_pkg::RRX_MASK;
                        s1_next.fill  = carry_in;
                        s1_next.carry = operand_value[0];
                    end
                    else if (amt_lo == 5'd0)
                    begin
                        s1_next.carry = operand_value[31];
                    end
                    else
                    begin
                        s1_next.rot   = amt_lo;
                        s1_next.carry = operand_value[amt_m1];
                    end
                end
                default:
                begin
                    s1_next.carry = carry_in;
                end
            endcase
        end
    end

    // stage 2: coarse rotate by whole bytes
    always_comb
    begin
        s2_next = s1_reg;
        unique case (s1_reg.rot[4:3])
            2'd0:    s2_next.value = s1_reg.value;
            2'd1:    s2_next.value = {s1_reg.value[7:0],  s1_reg.value[31:8]};
            2'd2:    s2_next.value = {s1_reg.value[15:0], s1_reg.value[31:16]};
            2'd3:    s2_next.value = {s1_reg.value[23:0], s1_reg.value[31:24]};
            default: s2_next.value = s1_reg.value;
        endcase
    end

    // stage 3: fine rotate
    always_comb
    begin
        s3_next       = s2_reg;
        s3_next.value = (s2_reg.value >> s2_reg.rot[2:0])
                      | (s2_reg.value << (6'd32 - {3'b000, s2_reg.rot[2:0]}));
    end

    // stage 4: mask and fill
    assign value_next = (s3_reg.value & s3_reg.mask) | (~s3_reg.mask & {32{s3_reg.fill}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        s3_reg    <= s3_next;
        value_reg <= value_next;
        carry_reg <= s3_reg.carry;
    end

    assign done          = v4_reg;
    assign shifted_value = value_reg;
    assign shift_carry   = carry_reg;

endmodule

>>> rtl/sowc_checker.sv
module sowc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [7:0]  shift_encoding,
    input logic [31:0] operand_value,
    input logic [7:0]  amount_reg_byte,
    input logic        carry_in,
    input logic        done,
    input logic [31:0] shifted_value,
    input logic        shift_carry
);

    logic [3:0] rst_hist_reg;
    logic       warm;
    logic       pass_item;
    logic       lsr32_item;
    logic       asr32_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rst_hist_reg <= 4'd0;
        end
        else
        begin
            rst_hist_reg <= {rst_hist_reg[2:0], 1'b1};
        end
    end

    assign warm = &rst_hist_reg;

    assign pass_item  = start && shift_encoding[0] && amount_reg_byte == 8'd0;
    assign lsr32_item = start && shift_encoding[2:0] == 3'b010
                     && shift_encoding[7:3] == 5'd0;
    assign asr32_item = start && shift_encoding[2:0] == 3'b100
                     && shift_encoding[7:3] == 5'd0;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        warm |-> (done == $past(start, 4)))
        else $error("result strobe does not follow item by four cycles");

    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && $past(pass_item, 4)) |->
        (shifted_value == $past(operand_value, 4) && shift_carry == $past(carry_in, 4)))
        else $error("zero register amount did not pass value and carry");

    a_lsr32: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && $past(lsr32_item, 4)) |->
        (shifted_value == 32'd0 && shift_carry == $past(operand_value[31], 4)))
        else $error("immediate lsr zero not treated as lsr by 32");

    a_asr32: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && $past(asr32_item, 4)) |->
        (shifted_value == {32{$past(operand_value[31], 4)}}
         && shift_carry == $past(operand_value[31], 4)))
        else $error("immediate asr zero not treated as asr by 32");

endmodule

bind shifter_operand_with_carry_unit sowc_checker u_sowc_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .shift_encoding  (shift_encoding),
    .operand_value   (operand_value),
    .amount_reg_byte (amount_reg_byte),
    .carry_in        (carry_in),
    .done            (done),
    .shifted_value   (shifted_value),
    .shift_carry     (shift_carry)
);

>>> verif/shifter_operand_with_carry_unit_tb.sv
module shifter_operand_with_carry_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned RandomItems = 900;
    localparam int unsigned DrainCycles = 10;

    typedef struct packed {
        logic [31:0] value;
        logic        carry;
    } shift_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  shift_encoding;
    logic [31:0] operand_value;
    logic [7:0]  amount_reg_byte;
    logic        carry_in;
    logic        done;
    logic [31:0] shifted_value;
    logic        shift_carry;

    shift_result_t pending_results[$];
    int unsigned   mismatch_count;
    int unsigned   cycle_count;
    bit            no_idle;

    shifter_operand_with_carry_unit u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .shift_encoding  (shift_encoding),
        .operand_value   (operand_value),
        .amount_reg_byte (amount_reg_byte),
        .carry_in        (carry_in),
        .done            (done),
        .shifted_value   (shifted_value),
        .shift_carry     (shift_carry)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic shift_result_t predict_operand2(input logic [7:0] enc,
                                                       input logic [31:0] v,
                                                       input logic [7:0] rbyte,
                                                       input logic cin);
        shift_result_t         r;
        sowc_pkg::shift_kind_t kind;
        logic                  by_reg;
        int unsigned           n;
        int unsigned           m;
        by_reg = enc[0];
        kind   = sowc_pkg::shift_kind_t'(enc[2:1]);
        n      = by_reg ? int'(rbyte) : int'(enc[7:3]);
        r      = '{value: v, carry: cin};
        if (by_reg && n == 0)
        begin
            return r;
        end
        case (kind)
            sowc_pkg::SHIFT_LSL:
            begin
                if (n == 0)
                begin
                    r = '{value: v, carry: cin};
                end
                else if (n < 32)
                begin
                    r = '{value: v << n, carry: v[32-n]};
                end
                else if (n == 32)
                begin
                    r = '{value: '0, carry: v[0]};
                end
                else
                begin
                    r = '{value: '0, carry: 1'b0};
                end
            end
            sowc_pkg::SHIFT_LSR:
            begin
                if (n == 0)
                begin
                    n = 32;
                end
                if (n < 32)
                begin
                    r = '{value: v >> n, carry: v[n-1]};
                end
                else if (n == 32)
                begin
                    r = '{value: '0, carry: v[31]};
                end
                else
                begin
                    r = '{value: '0, carry: 1'b0};
                end
            end
            sowc_pkg::SHIFT_ASR:
            begin
                if (n == 0 || n >= 32)
                begin
                    r = '{value: {32{v[31]}}, carry: v[31]};
                end
                else
                begin
                    r = '{value: 32'($signed(v) >>> n), carry: v[n-1]};
                end
            end
            default:
            begin
                if (n == 0 && !by_reg)
                begin
                    r = '{value: {cin, v[31:1]}, carry: v[0]};
                end
                else
                begin
                    m = n % 32;
                    if (m == 0)
                    begin
                        r = '{value: v, carry: v[31]};
                    end
                    else
                    begin
                        r = '{value: (v >> m) | (v << (32 - m)), carry: v[m-1]};
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] make_encoding(input logic by_reg,
                                                 input sowc_pkg::shift_kind_t kind,
                                                 input logic [4:0] imm);
        return {imm, kind, by_reg};
    endfunction

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic send_item(input logic [7:0] enc, input logic [31:0] v,
                             input logic [7:0] rbyte, input logic cin);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start           <= 1'b1;
        shift_encoding  <= enc;
        operand_value   <= v;
        amount_reg_byte <= rbyte;
        carry_in        <= cin;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_operand2(enc, v, rbyte, cin));
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_immediate_forms();
        send_item(make_encoding(1'b0, sowc_pkg::SHIFT_LSL, 5'd0), 32'h8000_0001, 8'hA5, 1'b1);
        send_item(make_encoding(1'b0, sowc_pkg::SHIFT_LSL, 5'd1), 32'h8000_0000, 8'h00, 1'b0);
        send_item(make_encoding(1'b0, sowc_pkg::SHIFT_LSL, 5'd31), 32'hFFFF_FFFF, 8'hFF, 1'b0);
        send_item(make_encoding(1'b0, sowc_pkg::SHIFT_LSR, 5'd0), 32'h8000_0000, 8'h00, 1'b0);
        send_item(make_encoding(1'b0, sowc_pkg::SHIFT_LSR, 5'd31), 32'hFFFF_FFFF, 8'h5A, 1'b1);
        send_item(make_encoding(1'b0, sowc_pkg::SHIFT_ASR, 5'd0), 32'h8000_0000, 8'h00, 1'b0);
        send_item(make_encoding(1'b0, sowc_pkg::SHIFT_ASR, 5'd31), 32'h7FFF_FFFE, 8'hFF, 1'b1);
        send_item(make_encoding(1'b0, sowc_pkg::SHIFT_ROR, 5'd0), 32'h0000_0001, 8'h00, 1'b1);
        send_item(make_encoding(1'b0, sowc_pkg::SHIFT_ROR, 5'd31), 32'h8000_0001, 8'hFF, 1'b0);
    endtask

    task automatic test_register_forms();
        // imm bits are ignored in register mode
        send_item(make_encoding(1'b1, sowc_pkg::SHIFT_LSL, 5'd31), 32'hDEAD_BEEF, 8'd0, 1'b1);
        send_item(make_encoding(1'b1, sowc_pkg::SHIFT_ROR, 5'd0), 32'h1234_5678, 8'd0, 1'b0);
        send_item(make_encoding(1'b1, sowc_pkg::SHIFT_LSL, 5'd7), 32'h0000_0001, 8'd32, 1'b0);
        send_item(make_encoding(1'b1, sowc_pkg::SHIFT_LSR, 5'd0), 32'h8000_0000, 8'd32, 1'b0);
        send_item(make_encoding(1'b1, sowc_pkg::SHIFT_ASR, 5'd17), 32'h8000_0000, 8'd32, 1'b0);
        send_item(make_encoding(1'b1, sowc_pkg::SHIFT_ROR, 5'd3), 32'h8000_0001, 8'd32, 1'b0);
        send_item(make_encoding(1'b1, sowc_pkg::SHIFT_LSL, 5'd0), 32'hFFFF_FFFF, 8'd33, 1'b1);
        send_item(make_encoding(1'b1, sowc_pkg::SHIFT_LSR, 5'd0), 32'hFFFF_FFFF, 8'd33, 1'b1);
        send_item(make_encoding(1'b1, sowc_pkg::SHIFT_ASR, 5'd31), 32'h7FFF_FFFF, 8'd200, 1'b1);
        send_item(make_encoding(1'b1, sowc_pkg::SHIFT_ROR, 5'd0), 32'h0000_0001, 8'd64, 1'b0);
        send_item(make_encoding(1'b1, sowc_pkg::SHIFT_ROR, 5'd31), 32'h0000_0003, 8'd255, 1'b0);
    endtask

    task automatic test_random_items();
        logic [7:0]  enc;
        logic [31:0] v;
        logic [7:0]  rbyte;
        logic        cin;
        logic [7:0]  edge_amounts[8];
        edge_amounts = '{8'd0, 8'd1, 8'd31, 8'd32, 8'd33, 8'd63, 8'd64, 8'd255};
        for (int unsigned i = 0; i < RandomItems; i++)
        begin
            if (i % 150 == 0)
            begin
                no_idle = ($urandom_range(0, 2) == 0);
            end
            if (i == RandomItems / 2)
            begin
                wait_for_drain();
            end
            enc    = 8'($urandom);
            enc[0] = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0)
            begin
                rbyte = edge_amounts[$urandom_range(0, 7)];
            end
            else
            begin
                rbyte = 8'($urandom);
            end
            case ($urandom_range(0, 7))
                0: v = 32'hFFFF_FFFF;
                1: v = 32'h0000_0000;
                2: v = 32'h8000_0000;
                default: v = $urandom;
            endcase
            cin = 1'($urandom);
            send_item(enc, v, rbyte, cin);
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        shift_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result value %h carry %b", $time,
                         shifted_value, shift_carry);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (shifted_value !== want.value)
                begin
                    $display("%0t: shifted_value expected %h actual %h", $time,
                             want.value, shifted_value);
                    mismatch_count++;
                end
                if (shift_carry !== want.carry)
                begin
                    $display("%0t: shift_carry expected %b actual %b", $time,
                             want.carry, shift_carry);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        shift_encoding  = '0;
        operand_value   = '0;
        amount_reg_byte = '0;
        carry_in        = 1'b0;
        mismatch_count  = 0;
        cycle_count     = 0;
        no_idle         = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_immediate_forms();
        test_register_forms();
        wait_for_drain();
        test_random_items();

        wait_for_drain();
        repeat (DrainCycles) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/sowc_pkg.sv
rtl/shifter_operand_with_carry_unit.sv
rtl/sowc_checker.sv
verif/shifter_operand_with_carry_unit_tb.sv
